// ----- design/tbb_pkg.sv -----
package tbb_pkg;

  localparam int NowW    = 48;
  localparam int PeriodW = 32;
  localparam int TickW   = 10;
  localparam int BeatW   = 8;
  localparam int BarW    = 16;
  localparam int CfgIdxW = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TICKS_BEAT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BEATS_BAR   = 2'd2;

  localparam logic [PeriodW-1:0] TickPeriodReset = 32'd10000000;
  localparam logic [TickW-1:0]   TicksBeatReset  = 10'd24;
  localparam logic [BeatW-1:0]   BeatsBarReset   = 8'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load_run;      // capture lag of a new timestamp
    logic load_restart;  // restart the measure at the new timestamp
    logic emit_tick;     // count one tick and load its word
    logic emit_restart;  // load the restart word
    logic last;          // flag the loaded word as last of its run
  } tbb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic due;       // a tick is due now
    logic more;      // another tick is due after this one
    logic out_free;  // output register can take a word this cycle
  } tbb_stat_t;

endpackage

// ----- design/tempo_tick_beat_bar_counter_unit.sv -----
// Channel  Handshake          Word
// in_      in_valid/in_stall   now_ns[47:0], restart
// out_     out_valid/out_stall tick_index, beat_index, bar_index, elapsed_ns,
//                              beat_event, bar_event, last_of_run
// cfg_     cfg_valid/cfg_ready cfg_index[1:0], cfg_data[31:0]
//
// A timestamp first has its lag captured, then one tick word is loaded per
// cycle while the output is free, so an item with n due ticks yields n words
// (n up to MAX_CATCHUP); an item with no tick due yields none, a restart one.
// The per-tick pace is set by the lag subtract and the count update loop.
// Reset is synchronous on rst_n and restores the register defaults.
// out_stall holds the pending word and pauses the tick loop; the next item is
// taken while the last word of a run still waits.
module tempo_tick_beat_bar_counter_unit import tbb_pkg::*; #(
  parameter int MAX_CATCHUP = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PeriodW-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [NowW-1:0]    in_now_ns,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TickW-1:0]   out_tick_index,
  output logic [BeatW-1:0]   out_beat_index,
  output logic [BarW-1:0]    out_bar_index,
  output logic [NowW-1:0]    out_elapsed_ns,
  output logic               out_beat_event,
  output logic               out_bar_event,
  output logic               out_last_of_run
);

  tbb_cmd_t  cmd;
  tbb_stat_t stat;

  assign cfg_ready = 1'b1;

  tbb_ctrl #(
    .MAX_CATCHUP (MAX_CATCHUP)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  tbb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_now_ns       (in_now_ns),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tick_index  (out_tick_index),
    .out_beat_index  (out_beat_index),
    .out_bar_index   (out_bar_index),
    .out_elapsed_ns  (out_elapsed_ns),
    .out_beat_event  (out_beat_event),
    .out_bar_event   (out_bar_event),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- design/tbb_ctrl.sv -----
module tbb_ctrl import tbb_pkg::*; #(
  parameter int MAX_CATCHUP = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_restart,
  output logic      in_stall,
  input  tbb_stat_t stat,
  output tbb_cmd_t  cmd
);

  localparam int CntW = (MAX_CATCHUP > 1) ? $clog2(MAX_CATCHUP) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_CATCHUP - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_REST = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            last_tick;

  assign in_stall  = (state_r != ST_IDLE);
  assign last_tick = !stat.more || (cnt_r == CntLast);

  // sequence one word per tick until the lag is caught up or the cap is hit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cmd.load_restart = 1'b1;
            state_nxt        = ST_REST;
          end else begin
            cmd.load_run = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!stat.due) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_tick = 1'b1;
          cmd.last      = last_tick;
          cnt_nxt       = cnt_r + 1'b1;
          if (last_tick) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REST: begin
        if (stat.out_free) begin
          cmd.emit_restart = 1'b1;
          cmd.last         = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/tbb_dp.sv -----
module tbb_dp import tbb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PeriodW-1:0] cfg_data,
  input  logic [NowW-1:0]    in_now_ns,
  input  tbb_cmd_t           cmd,
  output tbb_stat_t          stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TickW-1:0]   out_tick_index,
  output logic [BeatW-1:0]   out_beat_index,
  output logic [BarW-1:0]    out_bar_index,
  output logic [NowW-1:0]    out_elapsed_ns,
  output logic               out_beat_event,
  output logic               out_bar_event,
  output logic               out_last_of_run
);

  logic [PeriodW-1:0] period_r;
  logic [TickW-1:0]   ticks_beat_r;
  logic [BeatW-1:0]   beats_bar_r;

  logic [NowW-1:0]  last_r;
  logic [NowW-1:0]  elapsed_r;
  logic [TickW-1:0] tick_r;
  logic [BeatW-1:0] beat_r;
  logic [BarW-1:0]  bar_r;
  logic [NowW:0]    diff_r;     // now minus last tick, top bit is the borrow

  logic             out_valid_r;
  logic [TickW-1:0] out_tick_r;
  logic [BeatW-1:0] out_beat_r;
  logic [BarW-1:0]  out_bar_r;
  logic [NowW-1:0]  out_elapsed_r;
  logic             out_beat_ev_r;
  logic             out_bar_ev_r;
  logic             out_last_r;

  logic [NowW-1:0]  period_ext;
  logic [NowW:0]    diff_sub;
  logic [NowW-1:0]  last_nxt;
  logic [NowW-1:0]  elapsed_nxt;
  logic [TickW-1:0] tick_inc;
  logic [BeatW-1:0] beat_inc;
  logic [BarW-1:0]  bar_inc;
  logic [TickW-1:0] tick_nxt;
  logic [BeatW-1:0] beat_nxt;
  logic [BarW-1:0]  bar_nxt;
  logic             beat_ev;
  logic             bar_ev;

  assign period_ext = NowW'(period_r);

  // lag arithmetic: one subtract for this tick, a compare against two periods for the next
  assign diff_sub  = {1'b0, diff_r[NowW-1:0]} - {1'b0, period_ext};
  assign stat.due  = !diff_r[NowW] && !diff_sub[NowW];
  assign stat.more = (diff_r[NowW-1:0] >= {period_ext[NowW-2:0], 1'b0});
  assign stat.out_free = !out_valid_r || !out_stall;

  // advance tick, beat and bar counts by one tick
  always_comb begin
    last_nxt    = last_r + period_ext;
    elapsed_nxt = elapsed_r + period_ext;
    tick_inc    = tick_r + 1'b1;
    beat_inc    = beat_r + 1'b1;
    bar_inc     = bar_r + 1'b1;
    tick_nxt    = tick_inc;
    beat_nxt    = beat_r;
    bar_nxt     = bar_r;
    beat_ev     = 1'b0;
    bar_ev      = 1'b0;
    if (tick_inc == ticks_beat_r) begin
      tick_nxt = '0;
      beat_ev  = 1'b1;
      beat_nxt = beat_inc;
      if (beat_inc == beats_bar_r) begin
        beat_nxt = '0;
        bar_ev   = 1'b1;
        bar_nxt  = bar_inc;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= TickPeriodReset;
      ticks_beat_r <= TicksBeatReset;
      beats_bar_r  <= BeatsBarReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICK_PERIOD: period_r     <= cfg_data;
        REG_TICKS_BEAT:  ticks_beat_r <= cfg_data[TickW-1:0];
        REG_BEATS_BAR:   beats_bar_r  <= cfg_data[BeatW-1:0];
        default: begin
        end
      endcase
    end
  end

  // measure state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      elapsed_r <= '0;
      tick_r    <= '0;
      beat_r    <= '0;
      bar_r     <= '0;
    end else if (cmd.load_restart) begin
      last_r    <= in_now_ns;
      elapsed_r <= '0;
      tick_r    <= '0;
      beat_r    <= '0;
      bar_r     <= '0;
    end else if (cmd.emit_tick) begin
      last_r    <= last_nxt;
      elapsed_r <= elapsed_nxt;
      tick_r    <= tick_nxt;
      beat_r    <= beat_nxt;
      bar_r     <= bar_nxt;
    end
  end

  // lag register: capture on a new timestamp, drop one period per tick
  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      diff_r <= {1'b0, in_now_ns} - {1'b0, last_r};
    end else if (cmd.emit_tick) begin
      diff_r <= {1'b0, diff_sub[NowW-1:0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_tick || cmd.emit_restart) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_restart) begin
      out_tick_r    <= '0;
      out_beat_r    <= '0;
      out_bar_r     <= '0;
      out_elapsed_r <= '0;
      out_beat_ev_r <= 1'b1;
      out_bar_ev_r  <= 1'b1;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_tick) begin
      out_tick_r    <= tick_nxt;
      out_beat_r    <= beat_nxt;
      out_bar_r     <= bar_nxt;
      out_elapsed_r <= elapsed_nxt;
      out_beat_ev_r <= beat_ev;
      out_bar_ev_r  <= bar_ev;
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tick_index  = out_tick_r;
  assign out_beat_index  = out_beat_r;
  assign out_bar_index   = out_bar_r;
  assign out_elapsed_ns  = out_elapsed_r;
  assign out_beat_event  = out_beat_ev_r;
  assign out_bar_event   = out_bar_ev_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tbb_pkg::*;

  localparam int CatchupMax   = 64;
  localparam int SettleCycles = 10;
  localparam int StallMax     = 17;
  // slowest correct run is about 230 stamps of up to 64 words, each word at worst
  // held by the longest stall, plus gaps; the limit allows about seven such runs
  localparam longint CycleLimit = 2000000;

  // one result word as the block presents it
  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [BeatW-1:0] beat;
    logic [BarW-1:0]  bar;
    logic [NowW-1:0]  elapsed;
    logic             beat_ev;
    logic             bar_ev;
    logic             last;
  } tick_word_t;

  // Tempo state tracker and queue of tick words still owed by the block
  class tempo_board;
    logic [PeriodW-1:0] period;
    logic [TickW-1:0]   ticks_per_beat;
    logic [BeatW-1:0]   beats_per_bar;
    logic [NowW-1:0]    start_t;
    logic [NowW-1:0]    last_t;
    logic [TickW-1:0]   tick_n;
    logic [BeatW-1:0]   beat_n;
    logic [BarW-1:0]    bar_n;
    tick_word_t         due_words[$];
    int max_run;
    int errors, words_seen, stamps, restarts, capped_runs, beat_marks, bar_marks;

    function new(int max_run_i);
      max_run        = max_run_i;
      period         = TickPeriodReset;
      ticks_per_beat = TicksBeatReset;
      beats_per_bar  = BeatsBarReset;
      start_t        = '0;
      last_t         = '0;
      tick_n         = '0;
      beat_n         = '0;
      bar_n          = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [PeriodW-1:0] data);
      case (idx)
        REG_TICK_PERIOD: period = data;
        REG_TICKS_BEAT: ticks_per_beat = data[TickW-1:0];
        REG_BEATS_BAR: beats_per_bar = data[BeatW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the tick words that one accepted timestamp causes
    function void note_stamp(logic [NowW-1:0] now, logic restart);
      tick_word_t w;
      int n;
      n = 0;
      stamps++;
      if (restart) begin
        start_t = now;
        last_t  = now;
        tick_n  = '0;
        beat_n  = '0;
        bar_n   = '0;
        w = '0;
        w.beat_ev = 1'b1;
        w.bar_ev  = 1'b1;
        w.last    = 1'b1;
        due_words.insert(due_words.size(), w);
        restarts++;
        return;
      end
      // catch up on the lag, one period per word, capped per stamp
      while (n < max_run && now >= last_t && (now - last_t) >= {16'd0, period}) begin
        w = '0;
        last_t = last_t + {16'd0, period};
        tick_n = tick_n + 1'b1;
        if (tick_n == ticks_per_beat) begin
          tick_n    = '0;
          w.beat_ev = 1'b1;
          beat_n    = beat_n + 1'b1;
          if (beat_n == beats_per_bar) begin
            beat_n   = '0;
            w.bar_ev = 1'b1;
            bar_n    = bar_n + 1'b1;
          end
        end
        w.tick    = tick_n;
        w.beat    = beat_n;
        w.bar     = bar_n;
        w.elapsed = last_t - start_t;
        due_words.insert(due_words.size(), w);
        n++;
      end
      if (n > 0) due_words[$].last = 1'b1;
      if (n == max_run) capped_runs++;
    endfunction

    function bit field_ok(string name, logic [NowW-1:0] exp_v, logic [NowW-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one accepted word with the oldest owed word
    function void check_word(tick_word_t got);
      tick_word_t exp_w;
      bit ok;
      words_seen++;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, actual tick %0h beat %0h bar %0h elapsed %0h",
                 $time, got.tick, got.beat, got.bar, got.elapsed);
        errors++;
        return;
      end
      exp_w = due_words.pop_front();
      ok = 1'b1;
      ok &= field_ok("tick_index", exp_w.tick, got.tick);
      ok &= field_ok("beat_index", exp_w.beat, got.beat);
      ok &= field_ok("bar_index", exp_w.bar, got.bar);
      ok &= field_ok("elapsed_ns", exp_w.elapsed, got.elapsed);
      ok &= field_ok("beat_event", exp_w.beat_ev, got.beat_ev);
      ok &= field_ok("bar_event", exp_w.bar_ev, got.bar_ev);
      ok &= field_ok("last_of_run", exp_w.last, got.last);
      if (!ok) errors++;
      if (exp_w.beat_ev) beat_marks++;
      if (exp_w.bar_ev) bar_marks++;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [PeriodW-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [NowW-1:0]    in_now_ns;
  logic               in_restart;
  logic               out_valid;
  logic               out_stall;
  logic [TickW-1:0]   out_tick_index;
  logic [BeatW-1:0]   out_beat_index;
  logic [BarW-1:0]    out_bar_index;
  logic [NowW-1:0]    out_elapsed_ns;
  logic               out_beat_event;
  logic               out_bar_event;
  logic               out_last_of_run;

  tempo_board      board;
  logic [NowW-1:0] now_cursor;
  longint          cycles = 0;

  tempo_tick_beat_bar_counter_unit #(
    .MAX_CATCHUP(CatchupMax)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_ns      (in_now_ns),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tick_index (out_tick_index),
    .out_beat_index (out_beat_index),
    .out_bar_index  (out_bar_index),
    .out_elapsed_ns (out_elapsed_ns),
    .out_beat_event (out_beat_event),
    .out_bar_event  (out_bar_event),
    .out_last_of_run(out_last_of_run)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Present one timestamp word after an optional gap and wait for it to be taken
  task automatic send_stamp(input logic [NowW-1:0] stamp, input logic restart,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_now_ns  <= stamp;
    in_restart <= restart;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_stamp(stamp, restart);
  endtask

  // Hold the input side until every owed word is out, then let the block settle
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [PeriodW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_reg(idx, data);
  endtask

  // Write all three registers back to back; only called while idle
  task automatic load_regs(input logic [PeriodW-1:0] period, input logic [TickW-1:0] tib,
                           input logic [BeatW-1:0] bib);
    put_reg(REG_TICK_PERIOD, period);
    put_reg(REG_TICKS_BEAT, {22'd0, tib});
    put_reg(REG_BEATS_BAR, {24'd0, bib});
    cfg_valid <= 1'b0;
  endtask

  // Mostly forward-moving time with random lag; some restarts, repeats,
  // backward steps and lags beyond the catch-up cap
  task automatic run_phase(input int n_items, input int mult_max);
    int burst;
    int pick;
    int gap;
    logic restart;
    logic [PeriodW-1:0] p;
    longint unsigned step;
    burst = 0;
    p = board.period;
    repeat (n_items) begin
      restart = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        restart = 1'b1;
        now_cursor = 48'({$urandom, $urandom});
      end else if (pick < 12) begin
        now_cursor = now_cursor - 48'($urandom_range(1, 5000));
      end else if (pick < 17) begin
        now_cursor = now_cursor;
      end else if (pick < 21) begin
        now_cursor = now_cursor + 48'(64'(p) * 64'd70);
      end else begin
        step = 64'(p) * 64'($urandom_range(0, mult_max));
        if (p != 0) step = step + 64'($urandom % p);
        else step = step + 64'($urandom_range(0, 100));
        now_cursor = now_cursor + 48'(step);
      end
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 11) == 0) burst = $urandom_range(5, 15);
        gap = $urandom_range(0, StallMax);
      end
      send_stamp(now_cursor, restart, gap);
      if ($urandom_range(0, 39) == 0) pause_until_drained();
    end
  endtask

  // Take result words with random stalls, with quiet stretches of no stall
  initial begin : result_sink
    int hold;
    bit quiet;
    tick_word_t w;
    quiet = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      hold = quiet ? 0 : $urandom_range(0, StallMax);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      w.tick    = out_tick_index;
      w.beat    = out_beat_index;
      w.bar     = out_bar_index;
      w.elapsed = out_elapsed_ns;
      w.beat_ev = out_beat_event;
      w.bar_ev  = out_bar_event;
      w.last    = out_last_of_run;
      board.check_word(w);
    end
  end

  initial begin : stimulus
    board      = new(CatchupMax);
    now_cursor = '0;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_TICK_PERIOD;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_now_ns  <= '0;
    in_restart <= 1'b0;
    out_stall  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counting from reset state, no tick due, backward time, restarts at the extremes
    send_stamp(48'd0, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'd25000000, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'd24999999, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'hFFFF_FFFF_FFFF, 1'b1, $urandom_range(0, StallMax));
    send_stamp(48'd0, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'd1000, 1'b1, $urandom_range(0, StallMax));

    // lag beyond the cap, then the remainder on the next stamp
    pause_until_drained();
    load_regs(32'd1, 10'd3, 8'd2);
    send_stamp(48'd1100, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'd1100, 1'b0, 0);
    send_stamp(48'd1100, 1'b0, 0);

    // zero period: every stamp but a restart owes a full capped run
    pause_until_drained();
    load_regs(32'd0, 10'd1, 8'd1);
    send_stamp(48'd1100, 1'b0, $urandom_range(0, StallMax));
    send_stamp(48'd1200, 1'b1, 0);
    send_stamp(48'd1200, 1'b0, $urandom_range(0, StallMax));

    // widest register values
    pause_until_drained();
    load_regs(32'hFFFF_FFFF, 10'd1023, 8'd255);
    send_stamp(48'd0, 1'b1, $urandom_range(0, StallMax));
    send_stamp(48'h2_0000_0000, 1'b0, 0);
    send_stamp(48'hFFFF_FFFF_FFFF, 1'b0, $urandom_range(0, StallMax));

    // restart near the top of the time range, then time wraps backward
    pause_until_drained();
    load_regs(32'd5, 10'd24, 8'd4);
    send_stamp(48'hFFFF_FFFF_FFF0, 1'b1, $urandom_range(0, StallMax));
    send_stamp(48'hFFFF_FFFF_FFFF, 1'b0, 0);
    send_stamp(48'd0, 1'b0, $urandom_range(0, StallMax));

    // random phases; counts carried over between phases run above lowered limits
    pause_until_drained();
    now_cursor = '0;
    load_regs(32'd1, 10'd1023, 8'd255);
    send_stamp(now_cursor, 1'b1, 0);
    run_phase(24, 60);

    pause_until_drained();
    load_regs(32'($urandom_range(1, 1000)), 10'($urandom_range(1, 6)),
              8'($urandom_range(1, 4)));
    run_phase(50, 40);

    pause_until_drained();
    load_regs(32'($urandom_range(1, 3)), 10'd0, 8'd0);
    run_phase(45, 60);

    pause_until_drained();
    load_regs(32'd0, 10'($urandom_range(1, 1023)), 8'($urandom_range(1, 255)));
    run_phase(12, 4);

    pause_until_drained();
    load_regs(TickPeriodReset, TicksBeatReset, BeatsBarReset);
    run_phase(40, 4);

    pause_until_drained();
    load_regs(32'hFFFF_FFFF, 10'($urandom_range(1, 8)), 8'($urandom_range(1, 3)));
    run_phase(40, 3);

    pause_until_drained();
    $display("run covered %0d timestamps (%0d restarts, %0d runs hit the catch-up cap)",
             board.stamps, board.restarts, board.capped_runs);
    $display("checked %0d tick words with %0d beat starts and %0d bar starts",
             board.words_seen, board.beat_marks, board.bar_marks);
    if (board.errors == 0 && board.due_words.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d bad words, %0d words never seen", board.errors, board.due_words.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tbb_pkg.sv
design/tbb_ctrl.sv
design/tbb_dp.sv
design/tempo_tick_beat_bar_counter_unit.sv
bench/tb_top.sv
